[sv/rgb888_blit_pixel_packer_core_defines.svh]
// assertion macros shared by the blit pixel packer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RGB888_BLIT_PIXEL_PACKER_CORE_DEFINES_SVH
`define RGB888_BLIT_PIXEL_PACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RBPP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rbpp check failed");

// next-cycle implication, disabled during reset
`define RBPP_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rbpp check failed");

`endif

[sv/rbpp_pkg.sv]
// types, codes and the colour packing function of the blit pixel packer
// no dependencies
`timescale 1ns / 1ps

package rbpp_pkg;

  localparam int FMT_BITS    = 9;
  localparam int BPP_BITS    = 3;
  localparam int STRIDE_BITS = 16;
  localparam int VIRT_BITS   = 13;
  localparam int ADDR_BITS   = 30;
  localparam int PIX_BITS    = 32;
  localparam int COMP_BITS   = 8;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    REG_RED_FMT   = 3'd0,
    REG_GREEN_FMT = 3'd1,
    REG_BLUE_FMT  = 3'd2,
    REG_BPP       = 3'd3,
    REG_STRIDE    = 3'd4,
    REG_VIRT_W    = 3'd5,
    REG_VIRT_H    = 3'd6
  } reg_idx_t;

  localparam logic [FMT_BITS-1:0]    RED_FMT_RST   = 9'd176;
  localparam logic [FMT_BITS-1:0]    GREEN_FMT_RST = 9'd168;
  localparam logic [FMT_BITS-1:0]    BLUE_FMT_RST  = 9'd160;
  localparam logic [BPP_BITS-1:0]    BPP_RST       = 3'd4;
  localparam logic [STRIDE_BITS-1:0] STRIDE_RST    = 16'd0;
  localparam logic [VIRT_BITS-1:0]   VIRT_W_RST    = 13'd640;
  localparam logic [VIRT_BITS-1:0]   VIRT_H_RST    = 13'd480;

  localparam logic [BPP_BITS-1:0] BPP_MIN = 3'd2;
  localparam logic [BPP_BITS-1:0] BPP_MAX = 3'd4;

  // live configuration as seen by the datapath, pixel size already saturated
  typedef struct packed {
    logic [FMT_BITS-1:0]    red_format;
    logic [FMT_BITS-1:0]    green_format;
    logic [FMT_BITS-1:0]    blue_format;
    logic [BPP_BITS-1:0]    bpp;
    logic [STRIDE_BITS-1:0] line_stride;
    logic [VIRT_BITS-1:0]   virtual_width;
    logic [VIRT_BITS-1:0]   virtual_height;
  } cfg_t;

  // quantize one component to its length and place it at its bit offset
  function automatic logic [PIX_BITS-1:0] place_colour(
    input logic [COMP_BITS-1:0] comp,
    input logic [FMT_BITS-1:0]  fmt
  );
    logic [3:0]           len;
    logic [3:0]           shamt;
    logic [COMP_BITS-1:0] q;
    len = fmt[8:5];
    if (len > 4'd8) begin
      len = 4'd8;
    end
    shamt = 4'd8 - len;
    q = comp >> shamt;
    return {{(PIX_BITS-COMP_BITS){1'b0}}, q} << fmt[4:0];
  endfunction

endpackage

[sv/rbpp_cfg_regs.sv]
// apb register file for the blit pixel packer
// depends on rbpp_pkg
`timescale 1ns / 1ps

module rbpp_cfg_regs
  import rbpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic [FMT_BITS-1:0]    red_fmt;
  logic [FMT_BITS-1:0]    green_fmt;
  logic [FMT_BITS-1:0]    blue_fmt;
  logic [BPP_BITS-1:0]    bpp_raw;
  logic [STRIDE_BITS-1:0] stride;
  logic [VIRT_BITS-1:0]   virt_w;
  logic [VIRT_BITS-1:0]   virt_h;
  reg_idx_t               idx;
  logic                   wr;

  assign idx = reg_idx_t'(paddr[4:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_fmt   <= RED_FMT_RST;
      green_fmt <= GREEN_FMT_RST;
      blue_fmt  <= BLUE_FMT_RST;
      bpp_raw   <= BPP_RST;
      stride    <= STRIDE_RST;
      virt_w    <= VIRT_W_RST;
      virt_h    <= VIRT_H_RST;
    end else if (wr) begin
      case (idx)
        REG_RED_FMT:   red_fmt   <= pwdata[FMT_BITS-1:0];
        REG_GREEN_FMT: green_fmt <= pwdata[FMT_BITS-1:0];
        REG_BLUE_FMT:  blue_fmt  <= pwdata[FMT_BITS-1:0];
        REG_BPP:       bpp_raw   <= pwdata[BPP_BITS-1:0];
        REG_STRIDE:    stride    <= pwdata[STRIDE_BITS-1:0];
        REG_VIRT_W:    virt_w    <= pwdata[VIRT_BITS-1:0];
        REG_VIRT_H:    virt_h    <= pwdata[VIRT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RED_FMT:   prdata = {{(32-FMT_BITS){1'b0}}, red_fmt};
      REG_GREEN_FMT: prdata = {{(32-FMT_BITS){1'b0}}, green_fmt};
      REG_BLUE_FMT:  prdata = {{(32-FMT_BITS){1'b0}}, blue_fmt};
      REG_BPP:       prdata = {{(32-BPP_BITS){1'b0}}, bpp_raw};
      REG_STRIDE:    prdata = {{(32-STRIDE_BITS){1'b0}}, stride};
      REG_VIRT_W:    prdata = {{(32-VIRT_BITS){1'b0}}, virt_w};
      REG_VIRT_H:    prdata = {{(32-VIRT_BITS){1'b0}}, virt_h};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.red_format     = red_fmt;
    cfg.green_format   = green_fmt;
    cfg.blue_format    = blue_fmt;
    cfg.line_stride    = stride;
    cfg.virtual_width  = virt_w;
    cfg.virtual_height = virt_h;
    if (bpp_raw < BPP_MIN) begin
      cfg.bpp = BPP_MIN;
    end else if (bpp_raw > BPP_MAX) begin
      cfg.bpp = BPP_MAX;
    end else begin
      cfg.bpp = bpp_raw;
    end
  end

endmodule

[sv/rbpp_job_tracker.sv]
// job state, raster counters and the input stage register
// depends on rbpp_pkg
`timescale 1ns / 1ps

module rbpp_job_tracker
  import rbpp_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  advance,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] pic_width,
  input  logic [COORD_BITS-1:0] pic_height,
  input  logic [COORD_BITS-1:0] dst_x,
  input  logic [COORD_BITS-1:0] dst_y,
  input  logic [COMP_BITS-1:0]  red,
  input  logic [COMP_BITS-1:0]  green,
  input  logic [COMP_BITS-1:0]  blue,
  output logic                  s1_valid,
  output logic [COORD_BITS:0]   s1_sx,
  output logic [COORD_BITS:0]   s1_sy,
  output logic                  s1_last,
  output logic [COMP_BITS-1:0]  s1_red,
  output logic [COMP_BITS-1:0]  s1_green,
  output logic [COMP_BITS-1:0]  s1_blue
);

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] job_width;
  logic [COORD_BITS-1:0] job_height;
  logic [COORD_BITS-1:0] job_x;
  logic [COORD_BITS-1:0] job_y;
  logic                  job_active;

  logic [COORD_BITS:0]   col_inc;
  logic [COORD_BITS:0]   row_inc;
  logic                  last;
  logic                  take_pixel;

  assign col_inc    = {1'b0, column_count} + 1'b1;
  assign row_inc    = {1'b0, row_count} + 1'b1;
  assign last       = (col_inc == {1'b0, job_width}) && (row_inc == {1'b0, job_height});
  assign take_pixel = in_fire && (req_type == REQ_PIXEL) && job_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      job_width    <= '0;
      job_height   <= '0;
      job_x        <= '0;
      job_y        <= '0;
      job_active   <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      // stage holds until the output moves, refills from a taken pixel
      s1_valid <= take_pixel || (s1_valid && !advance);
      if (in_fire && (req_type == REQ_START)) begin
        job_width    <= pic_width;
        job_height   <= pic_height;
        job_x        <= dst_x;
        job_y        <= dst_y;
        column_count <= '0;
        row_count    <= '0;
        job_active   <= (pic_width != '0) && (pic_height != '0);
      end else if (take_pixel) begin
        if (last) begin
          job_active   <= 1'b0;
          column_count <= '0;
          row_count    <= '0;
        end else if (col_inc[COORD_BITS-1:0] >= job_width) begin
          column_count <= '0;
          row_count    <= row_inc[COORD_BITS-1:0];
        end else begin
          column_count <= col_inc[COORD_BITS-1:0];
        end
      end
    end
  end

  // screen position of this pixel, one bit wider than a coordinate
  always_ff @(posedge clk) begin
    if (take_pixel) begin
      s1_sx    <= {1'b0, column_count} + {1'b0, job_x};
      s1_sy    <= {1'b0, row_count} + {1'b0, job_y};
      s1_last  <= last;
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
    end
  end

endmodule

[sv/rbpp_formatter.sv]
// clip, address arithmetic, colour packing and the result register
// depends on rbpp_pkg
`timescale 1ns / 1ps

module rbpp_formatter
  import rbpp_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  cfg_t                  cfg,
  input  logic                  s1_valid,
  input  logic [COORD_BITS:0]   s1_sx,
  input  logic [COORD_BITS:0]   s1_sy,
  input  logic                  s1_last,
  input  logic [COMP_BITS-1:0]  s1_red,
  input  logic [COMP_BITS-1:0]  s1_green,
  input  logic [COMP_BITS-1:0]  s1_blue,
  output logic                  out_valid,
  output logic [ADDR_BITS-1:0]  write_address,
  output logic [PIX_BITS-1:0]   pixel_value,
  output logic [BPP_BITS-1:0]   byte_count,
  output logic                  write_enable,
  output logic                  last_pixel
);

  localparam int POS_W = COORD_BITS + 1;
  localparam int CMP_W = (POS_W > VIRT_BITS) ? POS_W : VIRT_BITS;
  localparam int ROW_W = POS_W + STRIDE_BITS;
  localparam int PROD_W = ROW_W + 1;
  localparam int SUM_W = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;

  logic                 on_screen;
  logic [ROW_W-1:0]     row_off;
  logic [POS_W+2:0]     col_off;
  logic [SUM_W-1:0]     addr_sum;
  logic [PIX_BITS-1:0]  packed_pix;

  assign on_screen = (CMP_W'(s1_sx) < CMP_W'(cfg.virtual_width)) &&
                     (CMP_W'(s1_sy) < CMP_W'(cfg.virtual_height));

  assign row_off  = ROW_W'(s1_sy) * ROW_W'(cfg.line_stride);
  assign col_off  = (POS_W+3)'(s1_sx) * (POS_W+3)'(cfg.bpp);
  assign addr_sum = SUM_W'(row_off) + SUM_W'(col_off);

  assign packed_pix = place_colour(s1_red, cfg.red_format)
                    | place_colour(s1_green, cfg.green_format)
                    | place_colour(s1_blue, cfg.blue_format);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      write_address <= on_screen ? addr_sum[ADDR_BITS-1:0] : '0;
      pixel_value   <= packed_pix;
      byte_count    <= cfg.bpp;
      write_enable  <= on_screen;
      last_pixel    <= s1_last;
    end
  end

endmodule

[sv/rgb888_blit_pixel_packer_core.sv]
// top level of the rgb888 blit pixel packer
// depends on rbpp_pkg, rbpp_cfg_regs, rbpp_job_tracker, rbpp_formatter
//
//   channel | direction | handshake            | contents
//   --------+-----------+----------------------+------------------------------------
//   in      | sink      | in_valid / in_ready  | start or pixel transaction
//   out     | source    | out_valid / out_ready| one frame buffer write per pixel
//   apb     | slave     | psel/penable/pready  | seven format and clip registers
//
// two register stages: the input stage snapshots the raster position, the
// output stage holds the packed pixel and its address
// one transaction per clock sustained while out_ready holds; a taken pixel is
// registered in the input stage, then in the output stage that drives the outputs
// start transactions and pixels outside an active job produce nothing
// a stalled output freezes both stages; the input stage still fills when empty
// synchronous active-high reset clears the job, counters and valid flags
`timescale 1ns / 1ps
`include "rgb888_blit_pixel_packer_core_defines.svh"

module rgb888_blit_pixel_packer_core
  import rbpp_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transaction channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] pic_width,
  input  logic [COORD_BITS-1:0] pic_height,
  input  logic [COORD_BITS-1:0] dst_x,
  input  logic [COORD_BITS-1:0] dst_y,
  input  logic [COMP_BITS-1:0]  red,
  input  logic [COMP_BITS-1:0]  green,
  input  logic [COMP_BITS-1:0]  blue,
  // output transaction channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_BITS-1:0]  write_address,
  output logic [PIX_BITS-1:0]   pixel_value,
  output logic [BPP_BITS-1:0]   byte_count,
  output logic                  write_enable,
  output logic                  last_pixel,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                  cfg;
  logic                  advance;
  logic                  in_fire;
  logic                  s1_valid;
  logic [COORD_BITS:0]   s1_sx;
  logic [COORD_BITS:0]   s1_sy;
  logic                  s1_last;
  logic [COMP_BITS-1:0]  s1_red;
  logic [COMP_BITS-1:0]  s1_green;
  logic [COMP_BITS-1:0]  s1_blue;

  assign pready = 1'b1;

  // output stage moves whenever it is empty or being drained
  assign advance  = !out_valid || out_ready;
  // input stage can take a transaction if it is empty or moving on
  assign in_ready = advance || !s1_valid;
  assign in_fire  = in_valid && in_ready;

  rbpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rbpp_job_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .advance    (advance),
    .req_type   (req_type),
    .pic_width  (pic_width),
    .pic_height (pic_height),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .s1_valid   (s1_valid),
    .s1_sx      (s1_sx),
    .s1_sy      (s1_sy),
    .s1_last    (s1_last),
    .s1_red     (s1_red),
    .s1_green   (s1_green),
    .s1_blue    (s1_blue)
  );

  rbpp_formatter #(
    .COORD_BITS (COORD_BITS)
  ) u_fmt (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .cfg           (cfg),
    .s1_valid      (s1_valid),
    .s1_sx         (s1_sx),
    .s1_sy         (s1_sy),
    .s1_last       (s1_last),
    .s1_red        (s1_red),
    .s1_green      (s1_green),
    .s1_blue       (s1_blue),
    .out_valid     (out_valid),
    .write_address (write_address),
    .pixel_value   (pixel_value),
    .byte_count    (byte_count),
    .write_enable  (write_enable),
    .last_pixel    (last_pixel)
  );

  // clipped writes carry a zero address
  `RBPP_ASSERT_IMP(a_clip_addr, clk, rst, out_valid && !write_enable, write_address == '0)
  // pixel size always saturated into two to four bytes
  `RBPP_ASSERT_IMP(a_bpp_range, clk, rst, out_valid,
                   (byte_count == BPP_MIN) || (byte_count == 3'd3) || (byte_count == BPP_MAX))
  // an empty output stage never blocks the input
  `RBPP_ASSERT_IMP(a_no_block, clk, rst, !out_valid, in_ready)
  // a queued pixel reaches the output on the next edge once the output moves
  `RBPP_ASSERT_NXT(a_s1_moves, clk, rst, s1_valid && advance, out_valid)

endmodule
